// File: rtl/mwpm_pkg.sv
// package: constants and types for the pair matching solver
`timescale 1ns / 1ps
`default_nettype none
package mwpm_pkg;
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned CoordBits = 12;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned IdxBits   = $clog2(MaxPoints);
  localparam int unsigned CntBits   = $clog2(MaxPoints + 1);
  localparam int unsigned TotalBits = 24;
  localparam int unsigned SqBits    = 2 * CoordBits + 1;
  localparam int unsigned SqrtSteps = (SqBits + 1) / 2 + FracBits;
  localparam int unsigned RootBits  = SqrtSteps;
  localparam int unsigned DistBits  = RootBits;
  localparam int unsigned RemBits   = RootBits + 2;
  localparam int unsigned StepBits  = $clog2(SqrtSteps + 1);
  localparam logic [TotalBits-1:0] TotalMax = '1;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusOdd  = 2'd1;
  localparam logic [1:0] StatusOver = 2'd2;

  typedef logic [MaxPoints-1:0] mask_t;
  typedef logic [IdxBits-1:0]   idx_t;

  typedef struct packed {
    logic               start;
    logic [SqBits-1:0]  sq;
  } sqrt_req_t;

  typedef struct packed {
    logic               done;
    logic [RootBits-1:0] root;
  } sqrt_rsp_t;
endpackage
`default_nettype wire

// File: rtl/mwpm_sqrt.sv
// iterative fixed-point square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mwpm_sqrt
  import mwpm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire sqrt_req_t req_i,
  output      sqrt_rsp_t rsp_o
);
  localparam int unsigned VBits = 2 * (SqrtSteps - FracBits);
  logic [VBits-1:0]    v_q, v_d;
  logic [RootBits-1:0] root_q, root_d;
  logic [RemBits-1:0]  rem_q, rem_d;
  logic [StepBits-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [RemBits-1:0]  rem_s, trial;

  always_comb begin
    v_d = v_q; root_d = root_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    rem_s = {rem_q[RemBits-3:0], v_q[VBits-1 -: 2]};
    trial = {root_q[RootBits-1:0], 2'b01};
    if (req_i.start) begin
      v_d = VBits'(req_i.sq); root_d = '0; rem_d = '0;
      cnt_d = StepBits'(SqrtSteps); busy_d = 1'b1;
    end else if (busy_q) begin
      v_d = v_q << 2;
      if (rem_s >= trial) begin
        rem_d = rem_s - trial; root_d = {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_d = rem_s; root_d = {root_q[RootBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepBits'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    v_q <= v_d; root_q <= root_d; rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;
endmodule
`default_nettype wire

// File: rtl/min_weight_pair_matching_dp.sv
// top level: point loading, distance build and memo dp over subset masks
`timescale 1ns / 1ps
`default_nettype none
// Points are taken one item per cycle while in_ready_o is high and kept in
// arrival order in a small point store. The item with last_point set closes
// the set; intake then stops while the solver works. For n stored points
// (even, no overflow) it first builds all n*n pairwise distances with a
// bit-serial square root unit. It then sweeps the memo memory from the full
// mask down to zero; a mask takes one StMRd step per partner position above
// the lowest free point, a StMWait and a StMAcc step more per free partner
// (the registered read of the memo memory for its successor mask), and one
// StMWr step to write back. Odd sets and overflow answer on the next cycle.
// One result item per closing item; its output register holds until taken,
// and the next set may load meanwhile.
module min_weight_pair_matching_dp
  import mwpm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [CoordBits-1:0] point_x_i,
  input  wire logic [CoordBits-1:0] point_y_i,
  input  wire logic                 last_point_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [TotalBits-1:0] total_length_o,
  output      logic [1:0]           status_o
);
  typedef enum logic [9:0] {
    StLoad  = 10'b0000000001,
    StPtRd  = 10'b0000000010,
    StSqrt  = 10'b0000000100,
    StMInit = 10'b0000001000,
    StMRd   = 10'b0000010000,
    StMWait = 10'b0000100000,
    StMAcc  = 10'b0001000000,
    StMWr   = 10'b0010000000,
    StFinRd = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // storage
  logic [2*CoordBits-1:0] point_mem [MaxPoints];
  logic [DistBits-1:0]    dist_mem  [MaxPoints*MaxPoints];
  logic [TotalBits-1:0]   memo_mem  [2**MaxPoints];

  logic [CntBits-1:0] count_q, count_d;
  logic               ovf_q, ovf_d;
  idx_t               i_q, i_d, k_q, k_d;
  logic [2*CoordBits-1:0] pa_q, pb_q;
  mask_t              mask_q, mask_d, full_q, full_d;
  idx_t               p1_q, p1_d;
  logic [CntBits-1:0] p2_q, p2_d;
  logic [TotalBits-1:0] best_q, best_d;
  logic               res_v_q, res_v_d;
  logic [TotalBits-1:0] res_t_q, res_t_d;
  logic [1:0]         res_s_q, res_s_d;
  logic               sqrt_wait_q, sqrt_wait_d;

  logic [TotalBits-1:0] memo_rd_q;
  logic [DistBits-1:0]  dist_rd_q;
  mask_t                memo_raddr;
  logic                 memo_we;
  mask_t                memo_waddr;
  logic [TotalBits-1:0] memo_wdata;
  logic                 dist_we;

  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  wire logic in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StLoad) && !(res_v_q && !out_ready_i && last_point_i);
  assign out_valid_o    = res_v_q;
  assign total_length_o = res_t_q;
  assign status_o       = res_s_q;

  // squared distance of the current pair
  logic signed [CoordBits:0] dx, dy;
  logic signed [2*CoordBits+1:0] dx2, dy2;
  logic [SqBits-1:0] sq;
  always_comb begin
    dx = $signed({1'b0, pb_q[CoordBits-1:0]}) - $signed({1'b0, pa_q[CoordBits-1:0]});
    dy = $signed({1'b0, pb_q[2*CoordBits-1:CoordBits]})
       - $signed({1'b0, pa_q[2*CoordBits-1:CoordBits]});
    dx2 = (2*CoordBits+2)'(dx) * (2*CoordBits+2)'(dx);
    dy2 = (2*CoordBits+2)'(dy) * (2*CoordBits+2)'(dy);
    sq = SqBits'($unsigned(dx2)) + SqBits'($unsigned(dy2));
  end
  assign sq_req.start = (state_q == StPtRd) && sqrt_wait_q;
  assign sq_req.sq    = sq;

  mwpm_sqrt u_sqrt (.clk_i, .rst_ni, .req_i(sq_req), .rsp_o(sq_rsp));

  // lowest clear bit of a mask (n at most MaxPoints)
  function automatic idx_t low_clear(mask_t m);
    idx_t r;
    r = '0;
    for (int j = MaxPoints - 1; j >= 0; j--) if (!m[j]) r = idx_t'(j);
    return r;
  endfunction

  logic [TotalBits:0] cand;
  mask_t p1_bit, p2_bit;
  always_comb begin
    p1_bit = mask_t'(1) << p1_q;
    p2_bit = mask_t'(1) << p2_q[IdxBits-1:0];
    cand = {1'b0, memo_rd_q} + (TotalBits+1)'(dist_rd_q);
  end

  always_comb begin
    state_d = state_q; count_d = count_q; ovf_d = ovf_q;
    i_d = i_q; k_d = k_q; mask_d = mask_q; full_d = full_q;
    p1_d = p1_q; p2_d = p2_q; best_d = best_q;
    res_v_d = res_v_q; res_t_d = res_t_q; res_s_d = res_s_q;
    sqrt_wait_d = sqrt_wait_q;
    memo_raddr = mask_q | p1_bit | p2_bit;
    memo_we = 1'b0; memo_waddr = mask_q; memo_wdata = best_q;
    dist_we = 1'b0;
    if (res_v_q && out_ready_i) res_v_d = 1'b0;
    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (count_q < CntBits'(MaxPoints)) count_d = count_q + 1'b1;
          else ovf_d = 1'b1;
          if (last_point_i) begin
            if (ovf_d || (count_q >= CntBits'(MaxPoints))) begin
              res_v_d = 1'b1; res_t_d = '0; res_s_d = StatusOver;
              count_d = '0; ovf_d = 1'b0;
            end else if (count_d[0]) begin
              res_v_d = 1'b1; res_t_d = '0; res_s_d = StatusOdd;
              count_d = '0; ovf_d = 1'b0;
            end else begin
              i_d = '0; k_d = '0; state_d = StPtRd; sqrt_wait_d = 1'b0;
              full_d = mask_t'((MaxPoints+1)'(1) << count_d) - 1'b1;
            end
          end
        end
      end
      StPtRd: begin
        // the two points are registered into pa_q and pb_q, and the root starts once sqrt_wait_q is set
        if (sqrt_wait_q) begin
          state_d = StSqrt; sqrt_wait_d = 1'b0;
        end else sqrt_wait_d = 1'b1;
      end
      StSqrt: begin
        if (sq_rsp.done) begin
          dist_we = 1'b1;
          state_d = StPtRd;
          if (CntBits'(k_q) == count_q - 1'b1) begin
            k_d = '0;
            if (CntBits'(i_q) == count_q - 1'b1) state_d = StMInit;
            else i_d = i_q + 1'b1;
          end else k_d = k_q + 1'b1;
        end
      end
      StMInit: begin
        memo_we = 1'b1; memo_waddr = full_q; memo_wdata = '0;
        mask_d = full_q - 1'b1;
        // full mask is never below 3 here when n>=2; n=0 handled below
        if (count_q == '0) begin
          state_d = StFinRd; mask_d = '0;
        end else begin
          p1_d = low_clear(full_q - 1'b1);
          p2_d = CntBits'(low_clear(full_q - 1'b1)) + 1'b1;
          best_d = TotalMax; state_d = StMRd;
        end
      end
      StMRd: begin
        if (p2_q >= count_q) state_d = StMWr;
        else if (mask_q[p2_q[IdxBits-1:0]]) p2_d = p2_q + 1'b1;
        else state_d = StMWait;
      end
      StMWait: state_d = StMAcc;
      StMAcc: begin
        if (cand[TotalBits] || (cand[TotalBits-1:0] >= best_q)) begin
          if (!cand[TotalBits] && cand[TotalBits-1:0] < best_q) best_d = cand[TotalBits-1:0];
        end else best_d = cand[TotalBits-1:0];
        p2_d = p2_q + 1'b1; state_d = StMRd;
      end
      StMWr: begin
        memo_we = 1'b1;
        if (mask_q == '0) state_d = StFinRd;
        else begin
          mask_d = mask_q - 1'b1;
          p1_d = low_clear(mask_q - 1'b1);
          p2_d = CntBits'(low_clear(mask_q - 1'b1)) + 1'b1;
          best_d = TotalMax; state_d = StMRd;
        end
      end
      StFinRd: begin
        if (!res_v_q || out_ready_i) begin
          res_v_d = 1'b1; res_s_d = StatusOk;
          res_t_d = (count_q == '0) ? '0 : best_q;
          count_d = '0; ovf_d = 1'b0; state_d = StLoad;
        end
      end
      StOut: state_d = StLoad;
      default: state_d = StLoad;
    endcase
  end

  // point store
  always_ff @(posedge clk_i) begin
    if (in_acc && count_q < CntBits'(MaxPoints))
      point_mem[count_q[IdxBits-1:0]] <= {point_y_i, point_x_i};
    pa_q <= point_mem[i_q];
    pb_q <= point_mem[k_q];
  end

  // distance table
  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[{i_q, k_q}] <= DistBits'(sq_rsp.root);
    dist_rd_q <= dist_mem[{p1_q, p2_q[IdxBits-1:0]}];
  end

  // memo memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (memo_we) memo_mem[memo_waddr] <= memo_wdata;
    memo_rd_q <= memo_mem[memo_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; count_q <= '0; ovf_q <= 1'b0; res_v_q <= 1'b0;
      sqrt_wait_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; ovf_q <= ovf_d; res_v_q <= res_v_d;
      sqrt_wait_q <= sqrt_wait_d;
    end
  end
  always_ff @(posedge clk_i) begin
    i_q <= i_d; k_q <= k_d; mask_q <= mask_d; full_q <= full_d;
    p1_q <= p1_d; p2_q <= p2_d; best_q <= best_d;
    res_t_q <= res_t_d; res_s_q <= res_s_d;
  end

  // the final mask-zero entry is what best_q holds when the sweep ends
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3)) else $error("bad status");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(MaxPoints)) else $error("count over capacity");
  a_no_intake_solve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> !in_ready_o) else $error("intake during solve");
  a_ok_zero_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StatusOk) |-> (total_length_o == '0))
    else $error("error result carries a total");
endmodule
`default_nettype wire
